/* hdl/flood_source_counter_core_defines.svh */
// Assertion macros for the flood source counter.
// Included by modules that carry concurrent checks.
`ifndef FLOOD_SOURCE_COUNTER_CORE_DEFINES_SVH
`define FLOOD_SOURCE_COUNTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/fsc_pkg.sv */
// Shared types and codes for the flood source counter.
// No dependencies.
`timescale 1ns / 1ps
package fsc_pkg;
   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_TICK   = 1'b1;
   localparam logic [1:0] KIND_SYN  = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_UDP  = 2'd2;
   localparam logic [1:0] KIND_ICMP = 2'd3;
   localparam logic [1:0] RES_STATUS = 2'd0;
   localparam logic [1:0] RES_ALERT  = 2'd1;
   localparam logic [1:0] RES_MARKER = 2'd2;
   localparam logic [1:0] ST_EXISTING = 2'd0;
   localparam logic [1:0] ST_NEW      = 2'd1;
   localparam logic [1:0] ST_DST_FULL = 2'd2;
   localparam logic [1:0] ST_SRC_FULL = 2'd3;
   localparam logic [1:0] REG_SYN = 2'd0;
   localparam logic [1:0] REG_ACK = 2'd1;
   localparam logic [1:0] REG_UDP = 2'd2;

   typedef struct packed {
      logic        command;
      logic [1:0]  flood_kind;
      logic [31:0] dst_address;
      logic [15:0] dest_port;
      logic [31:0] src_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  status;
      logic [1:0]  alert_kind;
      logic [31:0] alert_address;
      logic [15:0] alert_port;
      logic [31:0] total_count;
      logic [4:0]  source_total;
      logic [31:0] lowest_source;
      logic [31:0] highest_source;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DST_SCAN, S_DST_DONE, S_SRC_SCAN, S_SRC_WAIT, S_SRC_DONE,
      S_TK_DST, S_TK_SRC, S_TK_WAIT, S_TK_EVAL, S_TK_MARK
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request
      logic dst_clear;   // reset destination scan
      logic dst_step;    // compare one destination
      logic dst_commit;  // resolve destination
      logic src_clear;
      logic src_step;    // issue one source slot read
      logic src_commit;
      logic tk_next_dst; // advance tick destination walk
      logic tk_src_step;
      logic tk_eval;     // emit alert if over threshold
      logic tk_mark;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tick;
      logic dst_last;    // scan at final destination or at a match
      logic dst_full;
      logic src_last;    // final source slot being issued
      logic tk_dst_ok;   // current walk destination is valid for kind
      logic tk_done;     // walk at final kind and destination
   } sts_type;
endpackage

/* hdl/fsc_ctrl.sv */
// Sequencer for packet lookup and interval close.
// Depends on fsc_pkg.
`timescale 1ns / 1ps
module fsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fsc_pkg::sts_type  sts,
   output fsc_pkg::ctl_type  ctl
);
   import fsc_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_DST_SCAN;
         S_DST_SCAN: begin
            if (sts.is_tick)       state_in = S_TK_DST;
            else if (sts.dst_last) state_in = S_DST_DONE;
         end
         S_DST_DONE: state_in = sts.dst_full ? S_IDLE : S_SRC_SCAN;
         S_SRC_SCAN: if (sts.src_last) state_in = S_SRC_WAIT;
         S_SRC_WAIT: state_in = S_SRC_DONE;
         S_SRC_DONE: state_in = S_IDLE;
         S_TK_DST: begin
            if (sts.tk_dst_ok)    state_in = S_TK_SRC;
            else if (sts.tk_done) state_in = S_TK_MARK;
         end
         S_TK_SRC:   if (sts.src_last) state_in = S_TK_WAIT;
         S_TK_WAIT:  state_in = S_TK_EVAL;
         S_TK_EVAL:  state_in = sts.tk_done ? S_TK_MARK : S_TK_DST;
         S_TK_MARK:  state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            ctl.load = start;
            ctl.dst_clear = start;
         end
         S_DST_SCAN: ctl.dst_step = !sts.is_tick;
         S_DST_DONE: begin
            ctl.dst_commit = 1'b1;
            ctl.src_clear = 1'b1;
         end
         S_SRC_SCAN: ctl.src_step = 1'b1;
         S_SRC_WAIT: ;
         S_SRC_DONE: ctl.src_commit = 1'b1;
         S_TK_DST: begin
            ctl.src_clear = 1'b1;
            ctl.tk_next_dst = !sts.tk_dst_ok && !sts.tk_done;
         end
         S_TK_SRC:   ctl.tk_src_step = 1'b1;
         S_TK_WAIT:  ;
         S_TK_EVAL: begin
            ctl.tk_eval = 1'b1;
            ctl.tk_next_dst = !sts.tk_done;
         end
         S_TK_MARK:  ctl.tk_mark = 1'b1;
         default: ;
      endcase
   end
endmodule

/* hdl/fsc_dp.sv */
// Tables, scan counters and result register.
// Depends on fsc_pkg and the defines header.
`timescale 1ns / 1ps
`include "flood_source_counter_core_defines.svh"
module fsc_dp #(
   parameter int DEST_ENTRIES = 16,
   parameter int SOURCES_PER_DEST = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  fsc_pkg::req_type  req,
   input  fsc_pkg::ctl_type  ctl,
   output fsc_pkg::sts_type  sts,
   input  logic [31:0]       thr_syn,
   input  logic [31:0]       thr_ack,
   input  logic [31:0]       thr_udp,
   output logic              rsp_strobe,
   output fsc_pkg::rsp_type  rsp
);
   import fsc_pkg::*;
   localparam int DW = (DEST_ENTRIES > 1) ? $clog2(DEST_ENTRIES) : 1;
   localparam int SW = (SOURCES_PER_DEST > 1) ? $clog2(SOURCES_PER_DEST) : 1;
   localparam int SLOTS = DEST_ENTRIES * SOURCES_PER_DEST;
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KW = 50;

   req_type req_ff;
   logic [KW-1:0] key;
   logic [DEST_ENTRIES-1:0] dvalid_ff;
   logic [KW-1:0] dkey_ff [DEST_ENTRIES];
   logic [SLOTS-1:0] svalid_ff;
   logic [31:0] saddr_mem [SLOTS];
   logic [31:0] scnt_mem [SLOTS];

   logic [DW-1:0] di_ff, dsel_ff, dfree_ff;
   logic dfound_ff, dfree_ok_ff;
   logic [SW-1:0] si_ff, ssel_ff, sfree_ff;
   logic shit_ff, sfree_ok_ff;
   logic [31:0] hcnt_ff;
   logic [1:0] tkind_ff;
   logic [DW-1:0] tdi_ff;
   logic [31:0] sum_ff, lo_ff, hi_ff;
   logic seen_ff;
   logic [4:0] held_ff;
   // read stage: slot data is registered and lands in the cycle after its address
   logic pk_ok_ff, tk_ok_ff, rd_sv_ff;
   logic [31:0] rd_addr_ff, rd_cnt_ff;
   logic [SW-1:0] rd_si_ff;
   logic [AW-1:0] rd_idx_ff;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic [AW-1:0] sidx, hit_idx, free_idx, cnt_wa;
   logic [32:0] sum_wide;
   logic [31:0] thr, cnt_wd;
   logic [DW-1:0] dbase;
   logic cnt_we, dst_full, dst_alloc, src_alloc, src_drop;

   assign key = {req_ff.flood_kind, req_ff.dst_address,
                 (req_ff.flood_kind == KIND_ICMP) ? 16'd0 : req_ff.dest_port};
   assign dbase = (req_ff.command == CMD_TICK) ? tdi_ff : dsel_ff;
   assign sidx = AW'(dbase * SOURCES_PER_DEST + si_ff);
   assign hit_idx = AW'(dsel_ff * SOURCES_PER_DEST + ssel_ff);
   assign free_idx = AW'(dsel_ff * SOURCES_PER_DEST + sfree_ff);
   assign sum_wide = {1'b0, sum_ff} + {1'b0, rd_cnt_ff};
   assign dst_full = !dfound_ff && !dfree_ok_ff;
   assign dst_alloc = ctl.dst_commit && !dfound_ff && dfree_ok_ff;
   assign src_alloc = ctl.src_commit && !shit_ff && sfree_ok_ff;
   assign src_drop = tk_ok_ff && rd_sv_ff && rd_cnt_ff == '0;

   always_comb begin
      unique case (tkind_ff)
         KIND_ACK: thr = thr_ack;
         KIND_UDP: thr = thr_udp;
         default:  thr = thr_syn;
      endcase
   end

   assign sts.is_tick   = req_ff.command == CMD_TICK;
   assign sts.dst_last  = di_ff == DW'(DEST_ENTRIES - 1) ||
                          (dvalid_ff[di_ff] && dkey_ff[di_ff] == key);
   assign sts.dst_full  = dst_full;
   assign sts.src_last  = si_ff == SW'(SOURCES_PER_DEST - 1);
   assign sts.tk_dst_ok = dvalid_ff[tdi_ff] && dkey_ff[tdi_ff][49:48] == tkind_ff;
   assign sts.tk_done   = tkind_ff == KIND_ICMP && tdi_ff == DW'(DEST_ENTRIES - 1);

   // single write port on the count table
   always_comb begin
      cnt_we = 1'b0;
      cnt_wa = hit_idx;
      cnt_wd = '0;
      if (ctl.src_commit && shit_ff) begin
         cnt_we = 1'b1;
         cnt_wd = (hcnt_ff == '1) ? hcnt_ff : hcnt_ff + 32'd1;
      end else if (src_alloc) begin
         cnt_we = 1'b1;
         cnt_wa = free_idx;
         cnt_wd = 32'd1;
      end else if (tk_ok_ff && rd_sv_ff && rd_cnt_ff != '0) begin
         cnt_we = 1'b1;
         cnt_wa = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (src_alloc) saddr_mem[free_idx] <= req_ff.src_address;
      if (cnt_we) scnt_mem[cnt_wa] <= cnt_wd;
      rd_addr_ff <= saddr_mem[sidx];
      rd_cnt_ff <= scnt_mem[sidx];
   end

   always_comb begin
      rsp_in = '0;
      rsp_strobe_in = 1'b0;
      if (ctl.dst_commit && dst_full) begin
         rsp_in.status = ST_DST_FULL;
         rsp_in.last = 1'b1;
         rsp_strobe_in = 1'b1;
      end
      if (ctl.src_commit) begin
         rsp_in.status = shit_ff ? ST_EXISTING : (sfree_ok_ff ? ST_NEW : ST_SRC_FULL);
         rsp_in.last = 1'b1;
         rsp_strobe_in = 1'b1;
      end
      if (ctl.tk_eval && sum_ff > thr) begin
         rsp_in.result_kind = RES_ALERT;
         rsp_in.alert_kind = tkind_ff;
         rsp_in.alert_address = dkey_ff[tdi_ff][47:16];
         rsp_in.alert_port = dkey_ff[tdi_ff][15:0];
         rsp_in.total_count = sum_ff;
         rsp_in.source_total = held_ff;
         rsp_in.lowest_source = lo_ff;
         rsp_in.highest_source = hi_ff;
         rsp_strobe_in = 1'b1;
      end
      if (ctl.tk_mark) begin
         rsp_in.result_kind = RES_MARKER;
         rsp_in.last = 1'b1;
         rsp_strobe_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req;
      if (ctl.dst_clear) begin
         di_ff <= '0; dfound_ff <= 1'b0; dfree_ok_ff <= 1'b0;
         tkind_ff <= KIND_SYN; tdi_ff <= '0;
      end else begin
         if (ctl.dst_step) begin
            if (dvalid_ff[di_ff] && dkey_ff[di_ff] == key) begin
               dfound_ff <= 1'b1; dsel_ff <= di_ff;
            end else if (!dvalid_ff[di_ff] && !dfree_ok_ff) begin
               dfree_ok_ff <= 1'b1; dfree_ff <= di_ff;
            end
            if (di_ff != DW'(DEST_ENTRIES - 1)) di_ff <= di_ff + 1'b1;
         end
         if (ctl.tk_next_dst) begin
            if (tdi_ff == DW'(DEST_ENTRIES - 1)) begin
               tdi_ff <= '0;
               tkind_ff <= tkind_ff + 2'd1;
            end else tdi_ff <= tdi_ff + 1'b1;
         end
      end
      if (dst_alloc) begin
         dkey_ff[dfree_ff] <= key;
         dsel_ff <= dfree_ff;
      end
      rd_si_ff <= si_ff;
      rd_idx_ff <= sidx;
      if (ctl.src_clear) begin
         si_ff <= '0; shit_ff <= 1'b0; sfree_ok_ff <= 1'b0;
         sum_ff <= '0; held_ff <= '0; seen_ff <= 1'b0; lo_ff <= '0; hi_ff <= '0;
      end else begin
         if ((ctl.src_step || ctl.tk_src_step) && si_ff != SW'(SOURCES_PER_DEST - 1))
            si_ff <= si_ff + 1'b1;
         // packet compare on the slot read last cycle
         if (pk_ok_ff) begin
            if (rd_sv_ff && rd_addr_ff == req_ff.src_address) begin
               shit_ff <= 1'b1; ssel_ff <= rd_si_ff; hcnt_ff <= rd_cnt_ff;
            end else if (!rd_sv_ff && !sfree_ok_ff) begin
               sfree_ok_ff <= 1'b1; sfree_ff <= rd_si_ff;
            end
         end
         // tick: range over all held sources, sum and clear the counted ones
         if (tk_ok_ff && rd_sv_ff) begin
            if (!seen_ff || rd_addr_ff < lo_ff) lo_ff <= rd_addr_ff;
            if (!seen_ff || rd_addr_ff > hi_ff) hi_ff <= rd_addr_ff;
            seen_ff <= 1'b1;
            if (rd_cnt_ff != '0) begin
               sum_ff <= sum_wide[32] ? '1 : sum_wide[31:0];
               held_ff <= held_ff + 5'd1;
            end
         end
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
         svalid_ff <= '0;
         pk_ok_ff <= 1'b0;
         tk_ok_ff <= 1'b0;
         rd_sv_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (dst_alloc) dvalid_ff[dfree_ff] <= 1'b1;
         if (src_alloc) svalid_ff[free_idx] <= 1'b1;
         else if (src_drop) svalid_ff[rd_idx_ff] <= 1'b0;
         pk_ok_ff <= ctl.src_step;
         tk_ok_ff <= ctl.tk_src_step;
         rd_sv_ff <= svalid_ff[sidx];
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp = rsp_ff;

   `FSC_ASSERT_NEXT(a_commit_strobe, clock, reset, ctl.src_commit, rsp_strobe,
                    "packet commit gave no response")
   `FSC_ASSERT_NEXT(a_mark_last, clock, reset, ctl.tk_mark,
                    rsp_strobe && rsp.last && rsp.result_kind == RES_MARKER,
                    "tick marker missing")
   `FSC_ASSERT_IMPL(a_mid_is_alert, clock, reset, rsp_strobe && !rsp.last,
                    rsp.result_kind == RES_ALERT,
                    "non-final result is not an alert")
endmodule

/* hdl/flood_source_counter_core.sv */
// Top level of the flood source counter: threshold registers, sequencer and tables.
// Depends on fsc_pkg, fsc_ctrl and fsc_dp.
//
//  channel | direction | handshake
//  req_    | in        | start & !busy
//  rsp_    | out       | rsp_strobe, one cycle, no back pressure
//  csr_    | in        | csr_valid & csr_ready
//
// A packet holds busy while destination tags are compared one per cycle, stopping at a
// match; then every source slot goes through a registered table read and is compared in
// the cycle after. A full destination table ends in S_DST_DONE, after the destination
// scan.
// A tick walks every destination for each kind and reads every source slot of each held
// destination; alerts go out as they are found and a marker closes the tick.
// Each result shows the cycle after the step that makes it. Reset is synchronous and clears
// valid bits and thresholds; tables need no sweep. Results are never stalled; csr_ready is high.
`timescale 1ns / 1ps
module flood_source_counter_core #(
   parameter int DEST_ENTRIES = 16,
   parameter int SOURCES_PER_DEST = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fsc_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output fsc_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import fsc_pkg::*;
   logic [31:0] syn_ff, ack_ff, udp_ff;
   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         syn_ff <= '0; ack_ff <= '0; udp_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SYN: syn_ff <= csr_wdata;
            REG_ACK: ack_ff <= csr_wdata;
            REG_UDP: udp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   fsc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
   );

   fsc_dp #(.DEST_ENTRIES(DEST_ENTRIES), .SOURCES_PER_DEST(SOURCES_PER_DEST)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .ctl(ctl), .sts(sts),
      .thr_syn(syn_ff), .thr_ack(ack_ff), .thr_udp(udp_ff),
      .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );
endmodule

/* test/flood_source_counter_checker.sv */
// Checker for flood_source_counter_core: tracks csr and req transfers, predicts results.
// Depends on fsc_pkg; compares every rsp transfer against the oldest expected result.
`timescale 1ns / 1ps
module flood_source_counter_checker #(
   parameter int DEST_ENTRIES = 16,
   parameter int SOURCES_PER_DEST = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  fsc_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  fsc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output int               errors,
   output int               pending
);
   import fsc_pkg::*;

   localparam int SLOTS = DEST_ENTRIES * SOURCES_PER_DEST;

   logic [31:0] thr_syn, thr_ack, thr_udp;
   logic        dest_used [DEST_ENTRIES];
   logic [49:0] dest_tag [DEST_ENTRIES];
   logic        src_used [SLOTS];
   logic [31:0] src_addr [SLOTS];
   logic [31:0] src_hits [SLOTS];
   rsp_type     expected_rsp_q [$];
   int          mismatch_count;

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report(field, got, want);
   endtask

   function automatic logic [1:0] count_packet(req_type r);
      logic [49:0] tag;
      int d, free_d, s, free_s, i;
      tag = {r.flood_kind, r.dst_address, (r.flood_kind == KIND_ICMP) ? 16'h0 : r.dest_port};
      d = -1;
      free_d = -1;
      for (int k = 0; k < DEST_ENTRIES; k++) begin
         if (d < 0 && dest_used[k] && dest_tag[k] == tag)
            d = k;
         if (d < 0 && !dest_used[k] && free_d < 0)
            free_d = k;
      end
      if (d < 0) begin
         if (free_d < 0)
            return ST_DST_FULL;
         d = free_d;
         dest_used[d] = 1'b1;
         dest_tag[d] = tag;
      end
      free_s = -1;
      for (s = 0; s < SOURCES_PER_DEST; s++) begin
         i = d * SOURCES_PER_DEST + s;
         if (src_used[i] && src_addr[i] == r.src_address) begin
            if (src_hits[i] != 32'hFFFF_FFFF)
               src_hits[i]++;
            return ST_EXISTING;
         end
         if (!src_used[i] && free_s < 0)
            free_s = s;
      end
      if (free_s < 0)
         return ST_SRC_FULL;
      i = d * SOURCES_PER_DEST + free_s;
      src_used[i] = 1'b1;
      src_addr[i] = r.src_address;
      src_hits[i] = 32'd1;
      return ST_NEW;
   endfunction

   // Interval close: walk kinds in order, slots ascending, queue alerts then the marker.
   task automatic close_interval();
      rsp_type     res;
      logic [32:0] sum;
      logic [31:0] lo, hi, limit;
      logic [4:0]  held;
      logic        seen;
      int          i;
      for (int kind = 0; kind < 4; kind++) begin
         for (int d = 0; d < DEST_ENTRIES; d++) begin
            if (!dest_used[d] || dest_tag[d][49:48] != kind[1:0])
               continue;
            sum = '0;
            held = '0;
            lo = '0;
            hi = '0;
            seen = 1'b0;
            for (int s = 0; s < SOURCES_PER_DEST; s++) begin
               i = d * SOURCES_PER_DEST + s;
               if (!src_used[i])
                  continue;
               if (!seen || src_addr[i] < lo)
                  lo = src_addr[i];
               if (!seen || src_addr[i] > hi)
                  hi = src_addr[i];
               seen = 1'b1;
               if (src_hits[i] == 0) begin
                  src_used[i] = 1'b0;
               end else begin
                  sum = sum + src_hits[i];
                  if (sum[32])
                     sum = {1'b0, 32'hFFFF_FFFF};
                  src_hits[i] = '0;
                  held++;
               end
            end
            limit = (kind[1:0] == KIND_ACK) ? thr_ack :
                    (kind[1:0] == KIND_UDP) ? thr_udp : thr_syn;
            if (sum[31:0] > limit) begin
               res = '0;
               res.result_kind = RES_ALERT;
               res.alert_kind = kind[1:0];
               res.alert_address = dest_tag[d][47:16];
               res.alert_port = dest_tag[d][15:0];
               res.total_count = sum[31:0];
               res.source_total = held;
               res.lowest_source = lo;
               res.highest_source = hi;
               expected_rsp_q.push_back(res);
            end
         end
      end
      res = '0;
      res.result_kind = RES_MARKER;
      res.last = 1'b1;
      expected_rsp_q.push_back(res);
   endtask

   always @(posedge clock) begin
      rsp_type want, res;
      if (reset) begin
         thr_syn = '0;
         thr_ack = '0;
         thr_udp = '0;
         foreach (dest_used[k]) dest_used[k] = 1'b0;
         foreach (src_used[k]) src_used[k] = 1'b0;
         expected_rsp_q.delete();
         mismatch_count = 0;
      end else begin
         // results belong to earlier items, so compare before predicting
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               report("unexpected result kind", 32'(rsp_data.result_kind), '0);
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("result_kind", 32'(rsp_data.result_kind), 32'(want.result_kind));
               check_field("status", 32'(rsp_data.status), 32'(want.status));
               check_field("alert_kind", 32'(rsp_data.alert_kind), 32'(want.alert_kind));
               check_field("alert_address", rsp_data.alert_address, want.alert_address);
               check_field("alert_port", 32'(rsp_data.alert_port), 32'(want.alert_port));
               check_field("total_count", rsp_data.total_count, want.total_count);
               check_field("source_total", 32'(rsp_data.source_total),
                           32'(want.source_total));
               check_field("lowest_source", rsp_data.lowest_source, want.lowest_source);
               check_field("highest_source", rsp_data.highest_source, want.highest_source);
               check_field("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SYN: thr_syn = csr_wdata;
               REG_ACK: thr_ack = csr_wdata;
               REG_UDP: thr_udp = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_data.command == CMD_TICK) begin
               close_interval();
            end else begin
               res = '0;
               res.result_kind = RES_STATUS;
               res.status = count_packet(req_data);
               res.last = 1'b1;
               expected_rsp_q.push_back(res);
            end
         end
      end
      errors <= mismatch_count;
      pending <= expected_rsp_q.size();
   end
endmodule

/* test/tb.sv */
// Testbench top for flood_source_counter_core: clock, reset, stimulus and verdict.
// Depends on fsc_pkg, the core and flood_source_counter_checker.
`timescale 1ns / 1ps
module tb;
   import fsc_pkg::*;

   localparam int WATCHDOG_CYCLES = 5000;
   // a tick walks 4 x 16 destinations plus the source slots of each held one; leave margin
   localparam int SETTLE_CYCLES = 400;
   localparam int KEY_POOL = 20;
   localparam int SRC_POOL = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_SYN;
   logic [31:0] csr_wdata = '0;
   int          errors;
   int          pending;
   int          idle_cycles = 0;

   // traffic pools: a fixed set of flow keys and source addresses per run
   logic [1:0]  key_kind [KEY_POOL];
   logic [31:0] key_addr [KEY_POOL];
   logic [15:0] key_port [KEY_POOL];
   logic [31:0] src_pool [SRC_POOL];

   always #1 clock = ~clock;

   flood_source_counter_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   flood_source_counter_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   // watchdog: counts cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("flood_source_counter_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // start stays high between back-to-back items; data changes on the falling edge
   task automatic send(req_type r);
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int n);
      @(negedge clock);
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // let every expected result arrive, then give the block time to go idle
   task automatic drain();
      pause(1);
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_thresholds(logic [31:0] syn, logic [31:0] ack, logic [31:0] udp);
      write_reg(REG_SYN, syn);
      write_reg(REG_ACK, ack);
      write_reg(REG_UDP, udp);
   endtask

   function automatic req_type packet(logic [1:0] kind, logic [31:0] addr,
                                      logic [15:0] port, logic [31:0] src);
      req_type r;
      r = '0;
      r.command = CMD_PACKET;
      r.flood_kind = kind;
      r.dst_address = addr;
      r.dest_port = port;
      r.src_address = src;
      return r;
   endfunction

   function automatic req_type tick();
      req_type r;
      // fields other than command are don't-care on a tick; fill them anyway
      r = '0;
      r.flood_kind = 2'($urandom);
      r.dst_address = $urandom;
      r.dest_port = 16'($urandom);
      r.src_address = $urandom;
      r.command = CMD_TICK;
      return r;
   endfunction

   // mostly pool traffic with ticks sprinkled in, plus some fully random packets
   task automatic random_traffic(int n);
      int k, burst;
      req_type r;
      burst = $urandom_range(1, 12);
      for (int j = 0; j < n; j++) begin
         k = $urandom_range(0, KEY_POOL - 1);
         case ($urandom_range(0, 19))
            0, 1: r = tick();
            2, 3: r = packet(2'($urandom), $urandom, 16'($urandom), $urandom);
            default: r = packet(key_kind[k], key_addr[k],
                                (key_kind[k] == KIND_ICMP) ? 16'($urandom) : key_port[k],
                                src_pool[$urandom_range(0, SRC_POOL - 1)]);
         endcase
         send(r);
         if (--burst == 0) begin
            // some gaps short, some long, some none
            if ($urandom_range(0, 3) != 0)
               pause($urandom_range(0, 15));
            burst = $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      // first two keys sit at the field extremes, the rest are random
      key_kind[0] = KIND_SYN;
      key_addr[0] = 32'h0;
      key_port[0] = 16'h0;
      key_kind[1] = KIND_UDP;
      key_addr[1] = 32'hFFFF_FFFF;
      key_port[1] = 16'hFFFF;
      for (int k = 2; k < KEY_POOL; k++) begin
         key_kind[k] = 2'($urandom);
         key_addr[k] = $urandom;
         key_port[k] = 16'($urandom);
      end
      src_pool[0] = 32'h0;
      src_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < SRC_POOL; k++)
         src_pool[k] = $urandom;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero thresholds, so any counted interval alerts
      set_thresholds(32'h0, 32'h0, 32'h0);
      send(tick());                                                  // empty tables
      send(packet(KIND_SYN, 32'h0, 16'h0, 32'h0));                   // new destination
      send(packet(KIND_SYN, 32'h0, 16'h0, 32'h0));                   // existing source
      send(packet(KIND_SYN, 32'h0, 16'h0, 32'hFFFF_FFFF));           // second source
      send(packet(KIND_ACK, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0001));
      send(packet(KIND_UDP, 32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFE));
      send(packet(KIND_ICMP, 32'hC0A8_0001, 16'h1234, 32'h0A00_0001));
      send(packet(KIND_ICMP, 32'hC0A8_0001, 16'hABCD, 32'h0A00_0001)); // port ignored
      send(packet(KIND_ICMP, 32'hC0A8_0001, 16'h0, 32'h0A00_0002));
      pause(3);
      send(tick());                                                  // alerts in kind order
      send(packet(KIND_SYN, 32'h0, 16'h0, 32'h0));
      send(tick());                      // zero-count sources set lo/hi then drop
      send(tick());                      // destinations with no sources stay silent
      drain();

      set_thresholds(32'd2, 32'd1, 32'd3);
      random_traffic(40);
      drain();

      set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_traffic(20);
      send(tick());
      drain();

      set_thresholds($urandom_range(0, 6), 32'h0, $urandom);
      random_traffic(40);
      send(tick());

      // end of stimulus: wait for the last results, then let the block settle
      drain();
      if (errors == 0) begin
         $display("flood_source_counter_core verification clean");
      end else begin
         $display("flood_source_counter_core verification failed");
      end
      $finish;
   end
endmodule
